// ===== rtl/itfa_pkg.sv =====
// Shared types and constants for the integer to ASCII formatter.
package itfa_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned IN_W           = 32;
  localparam int unsigned CHAR_W         = 7;
  localparam int unsigned MUL_W          = 32;
  localparam int unsigned MAX_DIGITS     = 10;
  localparam int unsigned DIG_IDX_W      = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W          = $clog2(MAX_DIGITS + 2);
  localparam int unsigned PRE_W          = 2;
  localparam int unsigned FIFO_DEPTH     = 2;

  // q = (x * RECIP_10) >> RECIP_SHIFT is exact for any 32-bit x
  localparam logic [MUL_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int unsigned      RECIP_SHIFT = 35;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_LOWA  = 7'h61;
  localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
  localparam logic [3:0]        NIB_TEN  = 4'hA;

  localparam logic OP_DEC = 1'b0;
  localparam logic OP_HEX = 1'b1;

  // One formatted value: digits[k] has weight base^k.
  typedef struct packed {
    logic [MAX_DIGITS-1:0][3:0] digits;
    logic [DIG_IDX_W-1:0]       ndig;
    logic                       neg;
    logic                       hex;
  } itfa_rec_t;

endpackage

// ===== rtl/itfa_ifs.sv =====
// Valid/ready channel interfaces for values in and characters out.
interface itfa_in_if
  import itfa_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] value;
  logic                   op;

  modport source (output valid, output value, output op, input ready);
  modport sink   (input valid, input value, input op, output ready);
endinterface

interface itfa_out_if
  import itfa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ===== rtl/itfa_front.sv =====
// Front end: accepts a value and turns it into a digit record.
module itfa_front
  import itfa_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [IN_W-1:0] in_value_i,
  input  logic                   in_op_i,
  output logic                   push_o,
  output itfa_rec_t              rec_o,
  input  logic                   full_i
);

  localparam int unsigned NIBS = (VALUE_BITS + 3) / 4;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  itfa_rec_t             rec_q, rec_d;

  logic [VALUE_BITS-1:0] raw;
  logic                  neg;
  logic [NIBS*4-1:0]     raw_pad;
  logic [DIG_IDX_W-1:0]  hex_hi;
  logic [MUL_W-1:0]      mag_w, quo_w, quo10_w, rem_w;
  logic [2*MUL_W-1:0]    prod;

  assign raw     = in_value_i[VALUE_BITS-1:0];
  assign neg     = raw[VALUE_BITS-1] & (in_op_i == OP_DEC);
  assign raw_pad = (NIBS*4)'(raw);

  // highest nonzero nibble count
  always_comb begin
    hex_hi = '0;
    for (int k = 0; k < NIBS; k++) begin
      if (raw_pad[k*4 +: 4] != 4'h0) hex_hi = DIG_IDX_W'(k + 1);
    end
  end

  // one decimal digit per cycle via reciprocal multiply
  assign mag_w   = MUL_W'(mag_q);
  assign prod    = mag_w * RECIP_10;
  assign quo_w   = MUL_W'(prod >> RECIP_SHIFT);
  assign quo10_w = (quo_w << 3) + (quo_w << 1);
  assign rem_w   = mag_w - quo10_w;

  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    rec_d   = rec_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          rec_d.neg    = neg;
          rec_d.hex    = (in_op_i == OP_HEX);
          rec_d.digits = '0;
          if (in_op_i == OP_HEX) begin
            for (int k = 0; k < NIBS; k++) rec_d.digits[k] = raw_pad[k*4 +: 4];
            rec_d.ndig = (hex_hi == '0) ? DIG_IDX_W'(1) : hex_hi;
            state_d    = S_PUSH;
          end else begin
            rec_d.ndig = '0;
            mag_d      = neg ? (~raw + VALUE_BITS'(1)) : raw;
            state_d    = S_DIV;
          end
        end
      end
      S_DIV: begin
        rec_d.digits[rec_q.ndig] = rem_w[3:0];
        rec_d.ndig               = rec_q.ndig + DIG_IDX_W'(1);
        mag_d                    = quo_w[VALUE_BITS-1:0];
        if (quo_w == '0) state_d = S_PUSH;
      end
      S_PUSH: begin
        if (!full_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign push_o     = (state_q == S_PUSH) && !full_i;
  assign rec_o      = rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rec_q <= rec_d;
  end

endmodule

// ===== rtl/itfa_fifo.sv =====
// Short record queue between the front and back ends.
module itfa_fifo
  import itfa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  itfa_rec_t rec_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output itfa_rec_t head_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_BITS = $clog2(FIFO_DEPTH + 1);

  itfa_rec_t            mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]     wr_q, rd_q;
  logic [CNT_BITS-1:0]  cnt_q;

  assign full_o  = (cnt_q == CNT_BITS'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      if (pop_i)  rd_q <= (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CNT_BITS'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= rec_i;
  end

endmodule

// ===== rtl/itfa_back.sv =====
// Back end: walks a digit record and emits one character per word.
module itfa_back
  import itfa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  itfa_rec_t         head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CHAR_W-1:0] out_char_o,
  output logic              out_last_o
);

  logic [CNT_W-1:0]     idx_q;
  logic                 valid_q;
  logic [CHAR_W-1:0]    char_q;
  logic                 last_q;

  logic [PRE_W-1:0]     pre;
  logic [CNT_W-1:0]     total;
  logic [CNT_W-1:0]     dpos;
  logic [DIG_IDX_W-1:0] dsel;
  logic [3:0]           dig;
  logic [CHAR_W-1:0]    dig_ch, ch;
  logic                 is_last, load;

  assign pre   = head_i.hex ? PRE_W'(2) : (head_i.neg ? PRE_W'(1) : PRE_W'(0));
  assign total = CNT_W'(pre) + CNT_W'(head_i.ndig);
  // digits go out from the most significant one down
  assign dpos  = total - CNT_W'(1) - idx_q;
  assign dsel  = dpos[DIG_IDX_W-1:0];
  assign dig   = head_i.digits[dsel];
  assign dig_ch = (dig >= NIB_TEN) ? CH_LOWA + CHAR_W'(dig - NIB_TEN)
                                   : CH_ZERO + CHAR_W'(dig);

  always_comb begin
    if (idx_q < CNT_W'(pre)) begin
      if (head_i.hex) ch = (idx_q == '0) ? CH_ZERO : CH_X;
      else            ch = CH_MINUS;
    end else begin
      ch = dig_ch;
    end
  end

  assign is_last = (idx_q == total - CNT_W'(1));
  assign load    = !empty_i && (!valid_q || out_ready_i);
  assign pop_o   = load && is_last;

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? '0 : idx_q + CNT_W'(1);
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= ch;
      last_q <= is_last;
    end
  end

endmodule

// ===== rtl/integer_to_ascii_formatter_unit.sv =====
// Top level of the integer to ASCII formatter: front end, record queue, back end.
//
//  channel | dir | payload                       | word
//  src_i   | in  | value[31:0] signed, op        | one value to format
//  res_o   | out | char_code[6:0], last          | one ASCII character
//
// Front end: a hex value goes from idle straight to push; a decimal value, of D
//   digits (1..10), passes the divide state once per digit through the reciprocal
//   multiplier. The back end sends one character per cycle, 1..11 per value, while
//   a record waits and the output is ready; throughput is the slower of the two.
// Reset: rst_ni clears the front state, queue pointers and output valid.
// Stalls: a full queue holds the front in its push state; a stalled output
//   holds the back end, while the front keeps converting into the queue.
module integer_to_ascii_formatter_unit
  import itfa_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  itfa_in_if.sink     src_i,
  itfa_out_if.source  res_o
);

  // front -> queue
  logic      push, full;
  itfa_rec_t rec_new;
  // queue -> back
  logic      pop, empty;
  itfa_rec_t rec_head;

  // Classifies the value (sign, mode) and builds its digit record.
  itfa_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (src_i.valid),
    .in_ready_o (src_i.ready),
    .in_value_i (src_i.value),
    .in_op_i    (src_i.op),
    .push_o     (push),
    .rec_o      (rec_new),
    .full_i     (full)
  );

  // Two records deep: front can finish the next value while one is emitted.
  itfa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec_new),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (rec_head)
  );

  // Emits prefix then digits, most significant first, through an output register.
  itfa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (rec_head),
    .pop_o       (pop),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_char_o  (res_o.char_code),
    .out_last_o  (res_o.last)
  );

endmodule

// ===== dv/integer_to_ascii_formatter_unit_test.sv =====
// Testbench for the integer to ASCII formatter: directed and random stimulus with scoreboard.
`timescale 1ns / 100ps

module integer_to_ascii_formatter_unit_test;
  import itfa_pkg::*;

  localparam int unsigned ACTIVE_BITS = VALUE_BITS_DEF;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          TAIL_CYCLES = 40;
  localparam int          MAX_PRINTS  = 60;
  localparam int          PHASE_ITEMS = 100;

  typedef struct {
    logic [IN_W-1:0] value;
    logic            op;
  } fmt_req_t;

  typedef struct {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } char_exp_t;

  logic clk_i;
  logic rst_ni;

  itfa_in_if  src_if ();
  itfa_out_if res_if ();

  integer_to_ascii_formatter_unit #(
    .VALUE_BITS(ACTIVE_BITS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .src_i (src_if),
    .res_o (res_if)
  );

  // Values waiting to be sent, and characters the block still owes us.
  fmt_req_t  pending_q[$];
  char_exp_t expected_chars_q[$];

  int error_count    = 0;
  int cycle_count    = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  bit hold_src       = 1'b0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("MISMATCH %s: got 0x%0h expected 0x%0h", what, got, want);
  endtask

  // Builds the text of one value and queues its characters, last one flagged.
  function automatic void predict_text(input logic [IN_W-1:0] value, input logic op);
    logic [63:0]       mask;
    logic [63:0]       raw;
    logic [63:0]       mag;
    logic [3:0]        nib;
    logic [3:0]        digs[$];
    logic [CHAR_W-1:0] text[$];
    bit                negative;
    bit                started;
    int                top;
    int                sh;
    char_exp_t         ce;
    mask = (64'd1 << ACTIVE_BITS) - 64'd1;
    raw  = {32'd0, value} & mask;
    if (op == OP_DEC) begin
      negative = raw[ACTIVE_BITS-1];
      // magnitude as unsigned so the most negative value still works
      mag = negative ? ((~raw + 64'd1) & mask) : raw;
      do begin
        digs.push_front(4'(mag % 64'd10));
        mag = mag / 64'd10;
      end while (mag != 64'd0);
      if (negative) text.push_back(CH_MINUS);
      foreach (digs[k]) text.push_back(CH_ZERO + CHAR_W'(digs[k]));
    end else begin
      text.push_back(CH_ZERO);
      text.push_back(CH_X);
      started = 1'b0;
      top = ((ACTIVE_BITS + 3) / 4 - 1) * 4;
      for (sh = top; sh >= 0; sh -= 4) begin
        nib = 4'((raw >> sh) & 64'hF);
        // leading zero nibbles dropped, but the lowest one always printed
        if (nib == 4'h0 && !started && sh > 0) continue;
        started = 1'b1;
        if (nib >= NIB_TEN) text.push_back(CH_LOWA + CHAR_W'(nib - NIB_TEN));
        else                text.push_back(CH_ZERO + CHAR_W'(nib));
      end
    end
    foreach (text[k]) begin
      ce.char_code = text[k];
      ce.last      = (k == text.size() - 1);
      expected_chars_q.push_back(ce);
    end
  endfunction

  function automatic void add_value(input logic [IN_W-1:0] value, input logic op);
    fmt_req_t req;
    req.value = value;
    req.op    = op;
    pending_q.push_back(req);
  endfunction

  // Mix of full-width, short, near power-of-ten and sign-edge values.
  function automatic logic [IN_W-1:0] pick_value();
    logic [IN_W-1:0] v;
    int              p;
    case ($urandom_range(4))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(31);
      2: v = -($urandom >> $urandom_range(31));
      3: begin
        v = 32'd1;
        p = $urandom_range(9);
        repeat (p) v = v * 32'd10;
        v = v + IN_W'($urandom_range(2)) - 32'd1;
        if ($urandom_range(1)) v = -v;
      end
      default: v = $urandom_range(1) ? (32'h8000_0000 + IN_W'($urandom_range(3)))
                                     : (32'h7FFF_FFFF - IN_W'($urandom_range(3)));
    endcase
    return v;
  endfunction

  // Driver: one word in flight; the next one is picked only after acceptance.
  always @(posedge clk_i) begin
    fmt_req_t req;
    bit       busy;
    if (rst_ni) begin
      busy = src_if.valid && !src_if.ready;
      if (src_if.valid && src_if.ready) begin
        req = pending_q.pop_front();
        predict_text(req.value, req.op);
      end
      if (!busy) begin
        if (!hold_src && pending_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          src_if.valid <= 1'b1;
          src_if.value <= pending_q[0].value;
          src_if.op    <= pending_q[0].op;
        end else begin
          src_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted character with the oldest expectation.
  always @(posedge clk_i) begin
    char_exp_t ce;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (expected_chars_q.size() == 0) begin
          report_mismatch("char with nothing expected", int'(res_if.char_code), 0);
        end else begin
          ce = expected_chars_q.pop_front();
          if (res_if.char_code !== ce.char_code)
            report_mismatch("char_code", int'(res_if.char_code), int'(ce.char_code));
          if (res_if.last !== ce.last)
            report_mismatch("last", int'(res_if.last), int'(ce.last));
        end
      end
      res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("integer_to_ascii_formatter_unit verification failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_q.size() != 0 || src_if.valid) @(negedge clk_i);
    while (expected_chars_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int idle_cfg[4];
    int stall_cfg[4];
    idle_cfg  = '{0, 75, 0, 12};
    stall_cfg = '{0, 0, 75, 12};

    src_if.valid = 1'b0;
    src_if.value = '0;
    src_if.op    = OP_DEC;
    res_if.ready = 1'b0;
    rst_ni       = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: zero, +/-1, digit rollovers, both extremes, every hex letter.
    add_value(32'd0, OP_DEC);           add_value(32'd0, OP_HEX);
    add_value(32'd1, OP_DEC);           add_value(32'd1, OP_HEX);
    add_value(32'hFFFF_FFFF, OP_DEC);   add_value(32'hFFFF_FFFF, OP_HEX);
    add_value(32'd9, OP_DEC);           add_value(32'd9, OP_HEX);
    add_value(32'd10, OP_DEC);          add_value(32'd10, OP_HEX);
    add_value(-32'sd10, OP_DEC);        add_value(-32'sd10, OP_HEX);
    add_value(32'd100, OP_DEC);         add_value(32'd100, OP_HEX);
    add_value(32'd1000000000, OP_DEC);  add_value(32'd1000000000, OP_HEX);
    add_value(32'h7FFF_FFFF, OP_DEC);   add_value(32'h7FFF_FFFF, OP_HEX);
    add_value(32'h8000_0000, OP_DEC);   add_value(32'h8000_0000, OP_HEX);
    add_value(32'hABCD_EF01, OP_DEC);   add_value(32'hABCD_EF01, OP_HEX);
    add_value(32'h0000_000F, OP_DEC);   add_value(32'h0000_000F, OP_HEX);
    wait_drained();

    // Random phases with different idle/stall mixes.
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = idle_cfg[ph];
      sink_stall_pct = stall_cfg[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        add_value(pick_value(), $urandom_range(1) ? OP_HEX : OP_DEC);
        // mid-phase: hold the sender until every owed char is out
        if (ph == 1 && n == PHASE_ITEMS / 2) begin
          while (pending_q.size() != 0) @(negedge clk_i);
          hold_src = 1'b1;
          while (src_if.valid) @(negedge clk_i);
          while (expected_chars_q.size() != 0) @(negedge clk_i);
          hold_src = 1'b0;
        end
      end
      wait_drained();
    end

    // Let any stray output show up before the verdict.
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (expected_chars_q.size() != 0)
      report_mismatch("chars still owed at end", 0, expected_chars_q.size());

    if (error_count == 0) begin
      $display("integer_to_ascii_formatter_unit verification clean");
    end else begin
      $display("integer_to_ascii_formatter_unit verification failed");
    end
    $finish;
  end

endmodule
